[hw/rtl/tbp_pkg.sv]
// Shared types, constants and counter helpers for the two-bit branch predictor.
`timescale 1ns / 1ps
`default_nettype none

package tbp_pkg;

  localparam int unsigned ADDR_W            = 32;
  localparam int unsigned CTR_W             = 2;
  localparam int unsigned CNT_W             = 32;
  localparam int unsigned TABLE_ENTRIES_DEF = 1024;

  localparam logic [CTR_W-1:0] COUNTER_MIN = 2'd0;
  localparam logic [CTR_W-1:0] COUNTER_MAX = 2'd3;
  localparam logic [CNT_W-1:0] COUNT_MAX   = '1;

  typedef struct packed {
    logic              branch_taken;
    logic [ADDR_W-1:0] branch_address;
  } branch_t;

  typedef struct packed {
    logic             global_prediction;
    logic             table_prediction;
    logic             global_correct;
    logic             table_correct;
    logic [CNT_W-1:0] global_right_total;
    logic [CNT_W-1:0] global_wrong_total;
    logic [CNT_W-1:0] table_right_total;
    logic [CNT_W-1:0] table_wrong_total;
  } result_t;

  // Taken moves toward strongly taken (0), not taken toward strongly not taken (3).
  function automatic logic [CTR_W-1:0] next_counter(input logic [CTR_W-1:0] c,
                                                    input logic taken);
    logic [CTR_W-1:0] n;
    n = c;
    if (taken) begin
      if (c != COUNTER_MIN) n = c - 1'b1;
    end else begin
      if (c != COUNTER_MAX) n = c + 1'b1;
    end
    return n;
  endfunction

  // Values 0 and 1 predict taken.
  function automatic logic predicts_taken(input logic [CTR_W-1:0] c);
    return ~c[CTR_W-1];
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == COUNT_MAX) ? v : v + 1'b1;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/tbp_index.sv]
// Table index unit: branch address modulo the table size.
`timescale 1ns / 1ps
`default_nettype none

module tbp_index #(
  parameter int unsigned TABLE_ENTRIES = tbp_pkg::TABLE_ENTRIES_DEF,
  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [tbp_pkg::ADDR_W-1:0]  address,
  output logic                             done,
  output logic [IDX_W-1:0]                 index
);

  localparam bit IS_POW2 = ((TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0);

  generate
    if (IS_POW2) begin : g_pow2
      // Power-of-two table: take the low address bits.
      always_ff @(posedge clk) begin
        if (rst) begin
          done <= 1'b0;
        end else begin
          done <= start;
        end
      end

      always_ff @(posedge clk) begin
        if (start) begin
          index <= address[IDX_W-1:0];
        end
      end
    end else begin : g_iter
      // Restoring reduction, most significant address bits first.
      localparam int unsigned BITS_PER_STEP = 4;
      localparam int unsigned STEPS         = tbp_pkg::ADDR_W / BITS_PER_STEP;
      localparam int unsigned STEP_W        = $clog2(STEPS);
      localparam logic [IDX_W:0] ENTRIES_W  = (IDX_W + 1)'(TABLE_ENTRIES);

      logic [tbp_pkg::ADDR_W-1:0] addr_sh;
      logic [STEP_W-1:0]          step;
      logic                       busy;
      logic [IDX_W-1:0]           rem;
      logic [IDX_W-1:0]           rem_next;
      logic [IDX_W:0]             part;

      always_comb begin
        part = {1'b0, rem};
        for (int i = 0; i < BITS_PER_STEP; i++) begin
          part = {part[IDX_W-1:0], addr_sh[tbp_pkg::ADDR_W-1-i]};
          if (part >= ENTRIES_W) part = part - ENTRIES_W;
        end
        rem_next = part[IDX_W-1:0];
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          busy <= 1'b0;
          done <= 1'b0;
          step <= '0;
        end else begin
          done <= 1'b0;
          if (start) begin
            busy <= 1'b1;
            step <= '0;
          end else if (busy) begin
            step <= step + 1'b1;
            if (step == STEP_W'(STEPS - 1)) begin
              busy <= 1'b0;
              done <= 1'b1;
            end
          end
        end
      end

      always_ff @(posedge clk) begin
        if (start) begin
          addr_sh <= address;
          rem     <= '0;
        end else if (busy) begin
          addr_sh <= addr_sh << BITS_PER_STEP;
          rem     <= rem_next;
        end
      end

      assign index = rem;
    end
  endgenerate

endmodule

`default_nettype wire

[hw/rtl/two_bit_branch_predictor.sv]
// Two-bit branch predictor top level: global counter, counter table and hit statistics.
// Order: index unit, then the registered table read, then the write-back into the result
//   register (a non-power-of-two index reduction takes 4 address bits per cycle).
// A new branch is taken only once the previous one has been written back, and the
//   write-back waits while the result register still holds an untransferred result.
// Reset: synchronous; a clearing pass writes every table entry to strongly taken,
//   with branch_ready low until it ends. Counts reset to zero.
`timescale 1ns / 1ps
`default_nettype none

module two_bit_branch_predictor #(
  parameter int unsigned TABLE_ENTRIES = tbp_pkg::TABLE_ENTRIES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              branch_valid,
  output logic                   branch_ready,
  input  wire tbp_pkg::branch_t  branch,
  output logic                   result_valid,
  input  wire logic              result_ready,
  output tbp_pkg::result_t       result
);

  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_ENTRY = IDX_W'(TABLE_ENTRIES - 1);

  localparam logic [1:0] ST_CLEAR  = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_INDEX  = 2'd2;
  localparam logic [1:0] ST_UPDATE = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  // Counter table: one write port, one registered read port.
  logic [tbp_pkg::CTR_W-1:0] table_mem [TABLE_ENTRIES];
  logic [tbp_pkg::CTR_W-1:0] rd_data;
  logic                      rd_en;
  logic                      wr_en;
  logic [IDX_W-1:0]          wr_addr;
  logic [tbp_pkg::CTR_W-1:0] wr_data;

  logic [IDX_W-1:0] clr_addr;
  logic             taken;
  logic             accept;
  logic             commit;
  logic             idx_done;
  logic [IDX_W-1:0] idx;

  logic [tbp_pkg::CTR_W-1:0] global_counter;
  logic [tbp_pkg::CNT_W-1:0] global_right_count;
  logic [tbp_pkg::CNT_W-1:0] global_wrong_count;
  logic [tbp_pkg::CNT_W-1:0] table_right_count;
  logic [tbp_pkg::CNT_W-1:0] table_wrong_count;

  logic                      gpred;
  logic                      tpred;
  logic                      gok;
  logic                      tok;
  logic [tbp_pkg::CNT_W-1:0] global_right_next;
  logic [tbp_pkg::CNT_W-1:0] global_wrong_next;
  logic [tbp_pkg::CNT_W-1:0] table_right_next;
  logic [tbp_pkg::CNT_W-1:0] table_wrong_next;

  // Take a branch only when idle; the output register frees the input side.
  assign branch_ready = (state == ST_IDLE);
  assign accept       = branch_valid & branch_ready;
  // Issue the table read as soon as the index is ready.
  assign rd_en        = (state == ST_INDEX) & idx_done;
  // Write back and load the result once the output register can take it.
  assign commit       = (state == ST_UPDATE) & (~result_valid | result_ready);

  tbp_index #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_index (
    .clk     (clk),
    .rst     (rst),
    .start   (accept),
    .address (branch.branch_address),
    .done    (idx_done),
    .index   (idx)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:  if (clr_addr == LAST_ENTRY) state_next = ST_IDLE;
      ST_IDLE:   if (accept) state_next = ST_INDEX;
      ST_INDEX:  if (idx_done) state_next = ST_UPDATE;
      ST_UPDATE: if (commit) state_next = ST_IDLE;
      default:   state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      taken <= branch.branch_taken;
    end
  end

  // Predictions come from the state before this branch's update.
  always_comb begin
    gpred = tbp_pkg::predicts_taken(global_counter);
    tpred = tbp_pkg::predicts_taken(rd_data);
    gok   = (gpred == taken);
    tok   = (tpred == taken);
    global_right_next = gok ? tbp_pkg::sat_inc(global_right_count) : global_right_count;
    global_wrong_next = gok ? global_wrong_count : tbp_pkg::sat_inc(global_wrong_count);
    table_right_next  = tok ? tbp_pkg::sat_inc(table_right_count) : table_right_count;
    table_wrong_next  = tok ? table_wrong_count : tbp_pkg::sat_inc(table_wrong_count);
  end

  // Clearing pass owns the write port until it ends; then only commits write.
  assign wr_en   = (state == ST_CLEAR) | commit;
  assign wr_addr = (state == ST_CLEAR) ? clr_addr : idx;
  assign wr_data = (state == ST_CLEAR) ? tbp_pkg::COUNTER_MIN
                                       : tbp_pkg::next_counter(rd_data, taken);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      table_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= table_mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      global_counter     <= tbp_pkg::COUNTER_MIN;
      global_right_count <= '0;
      global_wrong_count <= '0;
      table_right_count  <= '0;
      table_wrong_count  <= '0;
    end else if (commit) begin
      global_counter     <= tbp_pkg::next_counter(global_counter, taken);
      global_right_count <= global_right_next;
      global_wrong_count <= global_wrong_next;
      table_right_count  <= table_right_next;
      table_wrong_count  <= table_wrong_next;
    end
  end

  // Output register: hold until the transfer, then drop valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (commit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      result.global_prediction  <= gpred;
      result.table_prediction   <= tpred;
      result.global_correct     <= gok;
      result.table_correct      <= tok;
      result.global_right_total <= global_right_next;
      result.global_wrong_total <= global_wrong_next;
      result.table_right_total  <= table_right_next;
      result.table_wrong_total  <= table_wrong_next;
    end
  end

  // The index unit reports only for an item waiting on it.
  a_idx_done_in_index: assert property (@(posedge clk) disable iff (rst)
    idx_done |-> (state == ST_INDEX))
    else $error("index done outside index state");

  // Update only follows a table read.
  a_update_after_read: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPDATE) |-> ($past(state) == ST_INDEX || $past(state) == ST_UPDATE))
    else $error("update state entered without a table read");

  // Statistics move only on a commit.
  a_counts_on_commit: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$past(commit)) |-> ($stable(global_right_count)
      && $stable(global_wrong_count) && $stable(table_right_count)
      && $stable(table_wrong_count) && $stable(global_counter)))
    else $error("statistics changed without a commit");

  // Clearing pass covers the whole table before the first branch.
  a_clear_complete: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && $past(state) == ST_CLEAR) |-> ($past(clr_addr) == LAST_ENTRY))
    else $error("clearing pass ended early");

endmodule

`default_nettype wire
